@@ src/smr_pkg.sv @@
// Shared sizes, register indexes, control structs and helpers for the spiral matrix reader.
// Used by smr_ctrl, smr_datapath and spiral_order_matrix_reader_top; depends on nothing.
package smr_pkg;

  // Matrix limits and derived widths.
  localparam int MAX_ROWS    = 8;
  localparam int MAX_COLUMNS = 8;
  localparam int DEPTH       = MAX_ROWS * MAX_COLUMNS;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int COUNT_W     = $clog2(DEPTH + 1);
  localparam int POS_W       = $clog2((MAX_ROWS > MAX_COLUMNS) ? MAX_ROWS : MAX_COLUMNS);
  localparam int DIM_W       = 4;
  localparam int TOTAL_W     = 2 * DIM_W;
  localparam int DATA_W      = 32;

  // Configuration port.
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = DIM_W;
  localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT    = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_COUNT = 1'd1;
  localparam logic [DIM_W-1:0] DIM_RESET   = 4'd8;
  localparam logic [DIM_W-1:0] ROWS_MAX    = DIM_W'(MAX_ROWS);
  localparam logic [DIM_W-1:0] COLUMNS_MAX = DIM_W'(MAX_COLUMNS);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // write the incoming element and bump the load count
    logic start;    // clear the load count and set the walker to the outer ring
    logic read;     // read the store at the walker position
    logic advance;  // step the walker to the next spiral position
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic load_done;  // the element now arriving completes the matrix
    logic last;       // the walker sits on the final spiral position
  } dp_status_t;

  // A zero dimension counts as one, and an oversized one as the limit.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] value,
                                                 input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] res;
    if (value == '0) begin
      res = DIM_W'(1);
    end else if (value > maxv) begin
      res = maxv;
    end else begin
      res = value;
    end
    return res;
  endfunction

endpackage

@@ src/smr_ctrl.sv @@
// Controller state machine for the spiral matrix reader.
// Depends on smr_pkg for the command and status structs.
module smr_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               out_stall,
  input  smr_pkg::dp_status_t status,
  output smr_pkg::ctrl_cmd_t  cmd,
  output logic               in_stall,
  output logic               out_valid
);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_READ,
    ST_SHOW
  } state_t;

  state_t state;
  state_t state_next;

  // The state register is the only storage here.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Commands and next state.
  always_comb begin
    cmd        = '0;
    state_next = state;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    case (state)
      ST_LOAD: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (status.load_done) begin
            cmd.start  = 1'b1;
            state_next = ST_READ;
          end
        end
      end
      ST_READ: begin
        cmd.read   = 1'b1;
        state_next = ST_SHOW;
      end
      ST_SHOW: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          if (status.last) begin
            state_next = ST_LOAD;
          end else begin
            cmd.advance = 1'b1;
            state_next  = ST_READ;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

endmodule

@@ src/smr_datapath.sv @@
// Datapath of the spiral matrix reader: configuration registers, element store,
// load counter and the spiral walker. Depends on smr_pkg.
module smr_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [smr_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [smr_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic signed [smr_pkg::DATA_W-1:0]  element_value,
  input  smr_pkg::ctrl_cmd_t                 cmd,
  output smr_pkg::dp_status_t                status,
  output logic signed [smr_pkg::DATA_W-1:0]  out_value
);

  localparam int EXT_W  = smr_pkg::POS_W + 1;
  localparam int PROD_W = smr_pkg::POS_W + smr_pkg::DIM_W;

  typedef enum logic [1:0] {
    SIDE_TOP,
    SIDE_RIGHT,
    SIDE_BOTTOM,
    SIDE_LEFT
  } side_t;

  logic [smr_pkg::DIM_W-1:0]   row_count;
  logic [smr_pkg::DIM_W-1:0]   column_count;
  logic [smr_pkg::DIM_W-1:0]   rows_used;
  logic [smr_pkg::DIM_W-1:0]   cols_used;
  logic [smr_pkg::TOTAL_W-1:0] total;
  logic [smr_pkg::COUNT_W-1:0] loaded_count;
  logic [smr_pkg::COUNT_W-1:0] count_inc;
  logic                        load_done;
  logic                        walk_last;

  logic signed [smr_pkg::DATA_W-1:0] store [smr_pkg::DEPTH];
  logic [PROD_W-1:0]                 addr_full;
  logic [smr_pkg::ADDR_W-1:0]        rd_addr;

  logic [smr_pkg::POS_W-1:0] top, left, bottom, right, pos_r, pos_c;
  logic [smr_pkg::POS_W-1:0] top_next, left_next, bottom_next, right_next;
  logic [smr_pkg::POS_W-1:0] pos_r_next, pos_c_next;
  side_t                     side, side_next;
  logic                      ring_end, more_rings;
  logic [EXT_W-1:0]          top_x, left_x, bottom_x, right_x, r_x, c_x;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= smr_pkg::DIM_RESET;
      column_count <= smr_pkg::DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        smr_pkg::REG_ROW_COUNT:    row_count    <= cfg_data;
        smr_pkg::REG_COLUMN_COUNT: column_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // Dimensions in use and the element total.
  always_comb begin
    rows_used = smr_pkg::clamp_dim(row_count, smr_pkg::ROWS_MAX);
    cols_used = smr_pkg::clamp_dim(column_count, smr_pkg::COLUMNS_MAX);
    total     = smr_pkg::TOTAL_W'(rows_used) * smr_pkg::TOTAL_W'(cols_used);
    count_inc = loaded_count + smr_pkg::COUNT_W'(1);
    load_done = smr_pkg::TOTAL_W'(count_inc) >= total;
  end

  // Status back to the controller.
  assign status = '{load_done: load_done, last: walk_last};

  // Load counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      loaded_count <= '0;
    end else if (cmd.start) begin
      loaded_count <= '0;
    end else if (cmd.load) begin
      loaded_count <= count_inc;
    end
  end

  // Element store: one write port for loading, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      store[loaded_count[smr_pkg::ADDR_W-1:0]] <= element_value;
    end
    if (cmd.read) begin
      out_value <= store[rd_addr];
    end
  end

  // Row-major address of the walker position.
  always_comb begin
    addr_full = PROD_W'(pos_r) * PROD_W'(cols_used) + PROD_W'(pos_c);
    rd_addr   = addr_full[smr_pkg::ADDR_W-1:0];
  end

  // Next spiral position from the current side and the ring bounds.
  always_comb begin
    top_x    = {1'b0, top};
    left_x   = {1'b0, left};
    bottom_x = {1'b0, bottom};
    right_x  = {1'b0, right};
    r_x      = {1'b0, pos_r};
    c_x      = {1'b0, pos_c};

    side_next   = side;
    pos_r_next  = pos_r;
    pos_c_next  = pos_c;
    top_next    = top;
    left_next   = left;
    bottom_next = bottom;
    right_next  = right;
    ring_end    = 1'b0;

    case (side)
      SIDE_TOP: begin
        if (c_x < right_x) begin
          pos_c_next = pos_c + smr_pkg::POS_W'(1);
        end else if (top_x < bottom_x) begin
          side_next  = SIDE_RIGHT;
          pos_r_next = top + smr_pkg::POS_W'(1);
        end else begin
          ring_end = 1'b1;
        end
      end
      SIDE_RIGHT: begin
        if (r_x < bottom_x) begin
          pos_r_next = pos_r + smr_pkg::POS_W'(1);
        end else if (left_x < right_x) begin
          side_next  = SIDE_BOTTOM;
          pos_c_next = right - smr_pkg::POS_W'(1);
        end else begin
          ring_end = 1'b1;
        end
      end
      SIDE_BOTTOM: begin
        if (c_x > left_x) begin
          pos_c_next = pos_c - smr_pkg::POS_W'(1);
        end else if (bottom_x > top_x + EXT_W'(1)) begin
          side_next  = SIDE_LEFT;
          pos_r_next = bottom - smr_pkg::POS_W'(1);
        end else begin
          ring_end = 1'b1;
        end
      end
      SIDE_LEFT: begin
        if (r_x > top_x + EXT_W'(1)) begin
          pos_r_next = pos_r - smr_pkg::POS_W'(1);
        end else begin
          ring_end = 1'b1;
        end
      end
      default: begin
        ring_end = 1'b1;
      end
    endcase

    // Another ring exists only if both spans still hold at least one cell.
    more_rings = (top_x + EXT_W'(2) <= bottom_x) && (left_x + EXT_W'(2) <= right_x);

    if (ring_end) begin
      side_next   = SIDE_TOP;
      top_next    = top + smr_pkg::POS_W'(1);
      left_next   = left + smr_pkg::POS_W'(1);
      bottom_next = bottom - smr_pkg::POS_W'(1);
      right_next  = right - smr_pkg::POS_W'(1);
      pos_r_next  = top + smr_pkg::POS_W'(1);
      pos_c_next  = left + smr_pkg::POS_W'(1);
    end

    walk_last = ring_end && !more_rings;
  end

  // Walker registers: set to the outer ring at start, stepped on advance.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      side   <= SIDE_TOP;
      top    <= '0;
      left   <= '0;
      bottom <= smr_pkg::POS_W'(rows_used - smr_pkg::DIM_W'(1));
      right  <= smr_pkg::POS_W'(cols_used - smr_pkg::DIM_W'(1));
      pos_r  <= '0;
      pos_c  <= '0;
    end else if (cmd.advance) begin
      side   <= side_next;
      top    <= top_next;
      left   <= left_next;
      bottom <= bottom_next;
      right  <= right_next;
      pos_r  <= pos_r_next;
      pos_c  <= pos_c_next;
    end
  end

endmodule

@@ src/spiral_order_matrix_reader_top.sv @@
// Spiral matrix reader: loads a matrix in row-major order and replays it in
// clockwise spiral order from the outer ring inward.
//
// Input channel (in_valid / in_stall / element_value): one signed 32-bit element
// per request, row-major. in_stall is low while the block is loading.
// Output channel (out_valid / out_stall / out_value / is_final): one element per
// request in spiral order; is_final marks the last element of a run.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 = row_count,
// 1 = column_count). A zero dimension counts as one, a value above eight as eight.
//
// Each accepted element is written to the element store. The request that
// completes the matrix starts the run. Each result is read from the store into
// a register (ST_READ) and then presented (ST_SHOW). Input is stalled for the
// whole run. When the receiver stalls, the current result holds until it is
// taken. Reset clears the load count and sets both dimensions to eight; the
// element store is not cleared. No run reads an entry that was not loaded, if
// the user does not write the dimensions mid-run; the block does not enforce it.
module spiral_order_matrix_reader_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [smr_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [smr_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [smr_pkg::DATA_W-1:0]  element_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [smr_pkg::DATA_W-1:0]  out_value,
  output logic                               is_final
);

  smr_pkg::ctrl_cmd_t  cmd;
  smr_pkg::dp_status_t status;

  // Sequencer.
  smr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  // Store, counters and walker.
  smr_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .element_value (element_value),
    .cmd           (cmd),
    .status        (status),
    .out_value     (out_value)
  );

  // The final flag follows the walker, which holds still while a result waits.
  assign is_final = status.last;

endmodule
